@@ design/tl_pkg.sv @@
package tl_pkg;

    // Datapath widths.
    localparam int POS_BITS = 32;
    localparam int LEN_BITS = 16;

    localparam logic [LEN_BITS-1:0] LEN_MAX = '1;

    // Depth of the request queue between the front and the back.
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    // Lexer modes.
    typedef enum logic [3:0] {
        M_IDLE,
        M_IDENT,
        M_INT,
        M_CQ,
        M_CHAVE,
        M_STR,
        M_LT,
        M_GT,
        M_EQ,
        M_BANG
    } mode_t;

    // Input kind codes.
    localparam logic ITEM_BYTE = 1'b0;
    localparam logic ITEM_END  = 1'b1;

    // Token kinds. Keywords take the codes 0 to 14 in table order.
    localparam int KW_COUNT = 15;
    localparam logic [5:0] K_IDENT  = 6'd15;
    localparam logic [5:0] K_INT    = 6'd16;
    localparam logic [5:0] K_CHAR   = 6'd17;
    localparam logic [5:0] K_STR    = 6'd18;
    localparam logic [5:0] K_PLUS   = 6'd19;
    localparam logic [5:0] K_MINU   = 6'd20;
    localparam logic [5:0] K_MULT   = 6'd21;
    localparam logic [5:0] K_DIV    = 6'd22;
    localparam logic [5:0] K_LSS    = 6'd23;
    localparam logic [5:0] K_LEQ    = 6'd24;
    localparam logic [5:0] K_GRE    = 6'd25;
    localparam logic [5:0] K_GEQ    = 6'd26;
    localparam logic [5:0] K_EQL    = 6'd27;
    localparam logic [5:0] K_ASSIGN = 6'd28;
    localparam logic [5:0] K_NEQ    = 6'd29;
    localparam logic [5:0] K_COLON  = 6'd30;
    localparam logic [5:0] K_SEMI   = 6'd31;
    localparam logic [5:0] K_COMMA  = 6'd32;
    localparam logic [5:0] K_LPAR   = 6'd33;
    localparam logic [5:0] K_RPAR   = 6'd34;
    localparam logic [5:0] K_LBRK   = 6'd35;
    localparam logic [5:0] K_RBRK   = 6'd36;
    localparam logic [5:0] K_LBRC   = 6'd37;
    localparam logic [5:0] K_RBRC   = 6'd38;
    localparam logic [5:0] K_END    = 6'd39;

    // Seven lower-cased letters, the first letter in element 0.
    typedef logic [0:6][7:0] kw_letters_t;

    localparam kw_letters_t KW_TEXT [KW_COUNT] = '{
        {"const", 16'h0}, {"int", 32'h0}, {"char", 24'h0}, {"void", 24'h0},
        {"main", 24'h0}, {"if", 40'h0}, {"else", 24'h0}, {"switch", 8'h0},
        {"case", 24'h0}, "default", {"while", 16'h0}, {"for", 32'h0},
        {"scanf", 16'h0}, {"printf", 8'h0}, {"return", 8'h0}
    };

    localparam logic [2:0] KW_LEN [KW_COUNT] = '{
        3'd5, 3'd3, 3'd4, 3'd4, 3'd4, 3'd2, 3'd4, 3'd6,
        3'd4, 3'd7, 3'd5, 3'd3, 3'd5, 3'd6, 3'd6
    };

    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
    } item_t;

    typedef struct packed {
        logic [5:0]          token_kind;
        logic [POS_BITS-1:0] token_start;
        logic [LEN_BITS-1:0] token_length;
        logic [7:0]          char_value;
        logic                length_saturated;
        logic                last;
    } result_t;

    // One or two results caused by a single input item.
    typedef struct packed {
        logic    two;
        result_t res0;
        result_t res1;
    } bundle_t;

    function automatic result_t mk_result(input logic [5:0] kind,
                                          input logic [POS_BITS-1:0] start,
                                          input logic [LEN_BITS-1:0] len,
                                          input logic [7:0] ch,
                                          input logic sat);
        result_t r;
        r.token_kind       = kind;
        r.token_start      = start;
        r.token_length     = len;
        r.char_value       = ch;
        r.length_saturated = sat;
        r.last             = 1'b0;
        return r;
    endfunction

    // Letters beyond the word length are always zero, so the whole row compares.
    function automatic logic [5:0] kw_lookup(input kw_letters_t letters,
                                             input logic [LEN_BITS-1:0] len);
        logic [5:0] k;
        k = K_IDENT;
        for (int i = KW_COUNT - 1; i >= 0; i--)
        begin
            if (len == LEN_BITS'(KW_LEN[i]) && letters == KW_TEXT[i])
            begin
                k = 6'(i);
            end
        end
        return k;
    endfunction

endpackage

@@ design/tl_front.sv @@
module tl_front import tl_pkg::*; (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    take,
    input  item_t   item,
    output logic    bundle_valid,
    output bundle_t bundle
);

    mode_t               mode_reg, mode_next;
    kw_letters_t         letters_reg, letters_next;
    logic [LEN_BITS-1:0] run_length_reg, run_length_next;
    logic [POS_BITS-1:0] run_start_reg, run_start_next;
    logic [POS_BITS-1:0] byte_offset_reg, byte_offset_next;
    logic [7:0]          held_char_reg, held_char_next;
    logic                len_sat_reg, len_sat_next;

    logic [7:0]          c;
    logic [7:0]          c_lower;
    logic                is_alpha, is_digit, is_space, is_word;
    logic [POS_BITS-1:0] pos;
    logic [5:0]          word_kind;
    logic [LEN_BITS-1:0] grow_len;
    logic                grow_sat;
    logic                used;
    logic                a_valid, b_valid;
    result_t             a_res, b_res;

    assign c        = item.data_byte;
    assign pos      = byte_offset_reg;
    assign is_alpha = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    assign is_digit = c >= "0" && c <= "9";
    assign is_space = c == " " || (c >= 8'd9 && c <= 8'd13);
    assign is_word  = is_alpha || is_digit || c == "_";
    assign c_lower  = (c >= "A" && c <= "Z") ? c + 8'd32 : c;

    assign word_kind = len_sat_reg ? K_IDENT : kw_lookup(letters_reg, run_length_reg);
    assign grow_sat  = len_sat_reg || run_length_reg == LEN_MAX;
    assign grow_len  = (run_length_reg == LEN_MAX) ? run_length_reg
                                                   : run_length_reg + 1'b1;

    always_comb
    begin
        mode_next        = mode_reg;
        letters_next     = letters_reg;
        run_length_next  = run_length_reg;
        run_start_next   = run_start_reg;
        byte_offset_next = byte_offset_reg;
        held_char_next   = held_char_reg;
        len_sat_next     = len_sat_reg;
        used             = 1'b0;
        a_valid          = 1'b0;
        b_valid          = 1'b0;
        a_res            = '0;
        b_res            = '0;

        if (item.kind == ITEM_END)
        begin
            unique case (mode_reg)
                M_IDENT:
                begin
                    a_valid = 1'b1;
                    a_res   = mk_result(word_kind, run_start_reg, run_length_reg,
                                        8'd0, len_sat_reg);
                end
                M_INT:
                begin
                    a_valid = 1'b1;
                    a_res   = mk_result(K_INT, run_start_reg, run_length_reg,
                                        8'd0, len_sat_reg);
                end
                M_LT:
                begin
                    a_valid = 1'b1;
                    a_res   = mk_result(K_LSS, run_start_reg, LEN_BITS'(1), 8'd0, 1'b0);
                end
                M_GT:
                begin
                    a_valid = 1'b1;
                    a_res   = mk_result(K_GRE, run_start_reg, LEN_BITS'(1), 8'd0, 1'b0);
                end
                M_EQ:
                begin
                    a_valid = 1'b1;
                    a_res   = mk_result(K_ASSIGN, run_start_reg, LEN_BITS'(1), 8'd0, 1'b0);
                end
                default:
                begin
                end
            endcase
            b_valid          = 1'b1;
            b_res            = mk_result(K_END, pos, '0, 8'd0, 1'b0);
            mode_next        = M_IDLE;
            byte_offset_next = '0;
        end
        else
        begin
            unique case (mode_reg)
                M_IDENT:
                begin
                    if (is_word)
                    begin
                        if (!len_sat_reg && run_length_reg < LEN_BITS'(7))
                        begin
                            letters_next[run_length_reg[2:0]] = c_lower;
                        end
                        run_length_next = grow_len;
                        len_sat_next    = grow_sat;
                        used            = 1'b1;
                    end
                    else
                    begin
                        a_valid   = 1'b1;
                        a_res     = mk_result(word_kind, run_start_reg, run_length_reg,
                                              8'd0, len_sat_reg);
                        mode_next = M_IDLE;
                    end
                end
                M_INT:
                begin
                    if (is_digit)
                    begin
                        run_length_next = grow_len;
                        len_sat_next    = grow_sat;
                        used            = 1'b1;
                    end
                    else
                    begin
                        a_valid   = 1'b1;
                        a_res     = mk_result(K_INT, run_start_reg, run_length_reg,
                                              8'd0, len_sat_reg);
                        mode_next = M_IDLE;
                    end
                end
                M_CQ:
                begin
                    held_char_next = c;
                    run_start_next = pos;
                    mode_next      = M_CHAVE;
                    used           = 1'b1;
                end
                M_CHAVE:
                begin
                    if (c == "'")
                    begin
                        a_valid = 1'b1;
                        a_res   = mk_result(K_CHAR, run_start_reg, LEN_BITS'(1),
                                            held_char_reg, 1'b0);
                    end
                    mode_next = M_IDLE;
                    used      = 1'b1;
                end
                M_STR:
                begin
                    if (c == "\"")
                    begin
                        a_valid   = 1'b1;
                        a_res     = mk_result(K_STR, run_start_reg, run_length_reg,
                                              8'd0, len_sat_reg);
                        mode_next = M_IDLE;
                    end
                    else
                    begin
                        run_length_next = grow_len;
                        len_sat_next    = grow_sat;
                    end
                    used = 1'b1;
                end
                M_LT, M_GT, M_EQ:
                begin
                    mode_next = M_IDLE;
                    a_valid   = 1'b1;
                    if (c == "=")
                    begin
                        used  = 1'b1;
                        a_res = mk_result((mode_reg == M_LT) ? K_LEQ :
                                          (mode_reg == M_GT) ? K_GEQ : K_EQL,
                                          run_start_reg, LEN_BITS'(2), 8'd0, 1'b0);
                    end
                    else
                    begin
                        a_res = mk_result((mode_reg == M_LT) ? K_LSS :
                                          (mode_reg == M_GT) ? K_GRE : K_ASSIGN,
                                          run_start_reg, LEN_BITS'(1), 8'd0, 1'b0);
                    end
                end
                M_BANG:
                begin
                    mode_next = M_IDLE;
                    if (c == "=")
                    begin
                        used    = 1'b1;
                        a_valid = 1'b1;
                        a_res   = mk_result(K_NEQ, run_start_reg, LEN_BITS'(2), 8'd0, 1'b0);
                    end
                end
                default:
                begin
                end
            endcase

            // A byte not consumed by the current token may start a new one.
            if (!used && !is_space)
            begin
                priority if (is_alpha || c == "_")
                begin
                    mode_next       = M_IDENT;
                    run_start_next  = pos;
                    run_length_next = LEN_BITS'(1);
                    len_sat_next    = 1'b0;
                    letters_next    = '0;
                    letters_next[0] = c_lower;
                end
                else if (is_digit)
                begin
                    mode_next       = M_INT;
                    run_start_next  = pos;
                    run_length_next = LEN_BITS'(1);
                    len_sat_next    = 1'b0;
                end
                else if (c == "'")
                begin
                    mode_next = M_CQ;
                end
                else if (c == "\"")
                begin
                    mode_next       = M_STR;
                    run_start_next  = pos + 1'b1;
                    run_length_next = '0;
                    len_sat_next    = 1'b0;
                end
                else if (c == "<" || c == ">" || c == "=" || c == "!")
                begin
                    mode_next       = (c == "<") ? M_LT : (c == ">") ? M_GT :
                                      (c == "=") ? M_EQ : M_BANG;
                    run_start_next  = pos;
                    run_length_next = LEN_BITS'(1);
                    len_sat_next    = 1'b0;
                end
                else
                begin
                    b_valid = 1'b1;
                    b_res   = mk_result(K_PLUS, pos, LEN_BITS'(1), 8'd0, 1'b0);
                    unique case (c)
                        "+": b_res.token_kind = K_PLUS;
                        "-": b_res.token_kind = K_MINU;
                        "*": b_res.token_kind = K_MULT;
                        "/": b_res.token_kind = K_DIV;
                        ":": b_res.token_kind = K_COLON;
                        ";": b_res.token_kind = K_SEMI;
                        ",": b_res.token_kind = K_COMMA;
                        "(": b_res.token_kind = K_LPAR;
                        ")": b_res.token_kind = K_RPAR;
                        "[": b_res.token_kind = K_LBRK;
                        "]": b_res.token_kind = K_RBRK;
                        "{": b_res.token_kind = K_LBRC;
                        "}": b_res.token_kind = K_RBRC;
                        default: b_valid = 1'b0;
                    endcase
                end
            end
            byte_offset_next = byte_offset_reg + 1'b1;
        end
    end

    // Pack the results in order and mark the final one.
    always_comb
    begin
        bundle_valid = take && (a_valid || b_valid);
        bundle       = '0;
        if (a_valid)
        begin
            bundle.res0 = a_res;
            bundle.res1 = b_res;
            bundle.two  = b_valid;
            if (b_valid)
            begin
                bundle.res1.last = 1'b1;
            end
            else
            begin
                bundle.res0.last = 1'b1;
            end
        end
        else
        begin
            bundle.res0      = b_res;
            bundle.res0.last = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= M_IDLE;
            letters_reg     <= '0;
            run_length_reg  <= '0;
            run_start_reg   <= '0;
            byte_offset_reg <= '0;
            held_char_reg   <= '0;
            len_sat_reg     <= 1'b0;
        end
        else if (take)
        begin
            mode_reg        <= mode_next;
            letters_reg     <= letters_next;
            run_length_reg  <= run_length_next;
            run_start_reg   <= run_start_next;
            byte_offset_reg <= byte_offset_next;
            held_char_reg   <= held_char_next;
            len_sat_reg     <= len_sat_next;
        end
    end

endmodule

@@ design/tl_queue.sv @@
module tl_queue import tl_pkg::*; (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    wr,
    input  bundle_t wr_data,
    output logic    full,
    input  logic    rd,
    output logic    rd_valid,
    output bundle_t rd_data
);

    bundle_t          mem_reg [QDEPTH];
    logic [QAW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QAW:0]     count_reg, count_next;
    logic             do_wr, do_rd;

    assign full     = count_reg == (QAW+1)'(QDEPTH);
    assign rd_valid = count_reg != '0;
    assign rd_data  = mem_reg[rd_ptr_reg];
    assign do_wr    = wr && !full;
    assign do_rd    = rd && rd_valid;

    always_comb
    begin
        count_next = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QAW'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QAW'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

endmodule

@@ design/tl_back.sv @@
module tl_back import tl_pkg::*; (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    q_valid,
    input  bundle_t q_head,
    output logic    q_rd,
    output logic    empty,
    input  logic    pop,
    output result_t result
);

    bundle_t bundle_reg;
    logic    valid_reg;
    logic    idx_reg;
    logic    taken;
    logic    done;

    assign empty  = !valid_reg;
    assign result = idx_reg ? bundle_reg.res1 : bundle_reg.res0;
    assign taken  = pop && valid_reg;
    assign done   = taken && (!bundle_reg.two || idx_reg);
    assign q_rd   = (!valid_reg || done) && q_valid;

    always_ff @(posedge clk)
    begin
        if (q_rd)
        begin
            bundle_reg <= q_head;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= 1'b0;
        end
        else if (q_rd)
        begin
            valid_reg <= 1'b1;
            idx_reg   <= 1'b0;
        end
        else if (done)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= 1'b0;
        end
        else if (taken)
        begin
            idx_reg <= 1'b1;
        end
    end

endmodule

@@ design/token_lexer_top.sv @@
// Streaming lexer for a small C subset. Each request carries one source byte or an
// end-of-input marker, and the block returns tokens as requests of kind, start
// offset, length, char literal value, a saturation flag and a last flag that marks
// the final token caused by one input request. A byte is accepted on every clock
// while full is low; the front lexer classifies it in the cycle it arrives, so
// there is no bubble between bytes. Tokens leave the output register one per
// clock while pop is high and tokens are waiting. The group holding a token is
// written into the queue on the edge that accepts the request completing it, and
// is then loaded into the output register that drives the result ports. One byte
// may complete a token and start a single-character one, giving two results;
// the four-entry queue between the lexer and the output stage absorbs the extra
// result. Such a byte always leaves the lexer idle, so the next byte gives at
// most one result and the tokens never outrun the bytes for long; full is
// therefore only asserted when the consumer stalls long enough for the queue to
// fill. Keywords are matched case-insensitively, whitespace and unknown bytes are
// skipped, and the byte offset restarts from zero after each end marker.
module token_lexer_top import tl_pkg::*; (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    output logic    full,
    input  item_t   item,
    output logic    empty,
    input  logic    pop,
    output result_t result
);

    logic    accept;
    logic    bundle_valid;
    bundle_t bundle;
    logic    q_valid;
    logic    q_rd;
    bundle_t q_head;

    // The lexer state only advances on an accepted request.
    assign accept = push && !full;

    tl_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .take         (accept),
        .item         (item),
        .bundle_valid (bundle_valid),
        .bundle       (bundle)
    );

    // Holds groups of one or two tokens until the output stage takes them.
    tl_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr       (bundle_valid),
        .wr_data  (bundle),
        .full     (full),
        .rd       (q_rd),
        .rd_valid (q_valid),
        .rd_data  (q_head)
    );

    // Output register: presents the tokens of each group in order.
    tl_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_head  (q_head),
        .q_rd    (q_rd),
        .empty   (empty),
        .pop     (pop),
        .result  (result)
    );

endmodule
